>>> rtl/bse_pkg.sv
// Shared types and constants for the bounded sequence engine.
// No dependencies; every other file of the block imports this package.
package bse_pkg;

	// Fixed port widths
	localparam int KIND_W   = 3;
	localparam int POS_W    = 9;
	localparam int WORD_W   = 32;
	localparam int INDEX_W  = 8;
	localparam int LEN_W    = 9;
	localparam int CAP_W    = 9;
	localparam int ADDR_W   = 3;
	localparam int APB_W    = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	// Register index codes (word address)
	typedef enum logic {
		REG_CAPACITY = 1'b0
	} reg_index_t;

	// Request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT_AT = 3'd0,
		KIND_SORTED    = 3'd1,
		KIND_ERASE_AT  = 3'd2,
		KIND_REMOVE    = 3'd3,
		KIND_GET       = 3'd4,
		KIND_SET       = 3'd5,
		KIND_FIND      = 3'd6
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_POS  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		CELL_HOLD = 3'd0,
		CELL_ROT  = 3'd1,
		CELL_INS  = 3'd2,
		CELL_DEL  = 3'd3,
		CELL_SET  = 3'd4,
		CELL_SWAP = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     phase;      // odd-even pairing for compaction
		logic     tail_mark;  // mark written into the last cell on rotation
	} cell_cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_DECIDE = 3'd1,
		S_SCAN   = 3'd2,
		S_EDIT   = 3'd3,
		S_SORT   = 3'd4,
		S_DONE   = 3'd5
	} state_t;

endpackage

>>> rtl/bounded_sequence_engine.sv
// Insert at, erase at, set, a full sorted insert and the unused kind go from the decide state
// straight to done; get and find first rotate the cell chain once to scan it; sorted insert
// scans, then inserts; remove all scans, then runs odd-even rounds to compact. One request at
// a time: start is taken again the cycle after done.
// Reset clears the length and control and sets capacity to 256; entries are kept.
// Depends on bse_pkg, bse_cell and bse_ctrl.
module bounded_sequence_engine import bse_pkg::*; #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [APB_W-1:0]     pwdata,
	output logic [APB_W-1:0]     prdata,
	output logic                 pready,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [POS_W-1:0]     position,
	input  logic [WORD_W-1:0]    item_value,
	output logic                 done,
	output logic [1:0]           status,
	output logic [INDEX_W-1:0]   result_index,
	output logic [WORD_W-1:0]    read_value,
	output logic [LEN_W-1:0]     removed_count,
	output logic [LEN_W-1:0]     length
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0]      capacity_q;
	logic                  reg_hit;
	cell_cmd_t             cmd;
	logic [CW-1:0]         cell_pos;
	logic [DATA_WIDTH-1:0] cell_word;
	logic [DATA_WIDTH-1:0] rvalue;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic                  cell_mark [DEPTH];

	// Capacity register
	assign reg_hit = paddr[2] == REG_CAPACITY;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = reg_hit ? APB_W'(capacity_q) : '0;

	// Sequencer
	bse_ctrl #(
		.DATA_WIDTH (DATA_WIDTH),
		.DEPTH      (DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.kind          (kind),
		.position      (position),
		.word          (DATA_WIDTH'(item_value)),
		.capacity      (capacity_q),
		.head_data     (cell_data[0]),
		.busy          (busy),
		.done          (done),
		.cmd           (cmd),
		.cell_pos      (cell_pos),
		.cell_word     (cell_word),
		.status        (status),
		.result_index  (result_index),
		.read_value    (rvalue),
		.removed_count (removed_count),
		.length        (length)
	);

	assign read_value = WORD_W'(rvalue);

	// Chain of cells; the last cell wraps to the head for rotation
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int L = (i == 0) ? DEPTH - 1 : i - 1;
		localparam int R = (i == DEPTH - 1) ? 0 : i + 1;
		logic r_mark;

		assign r_mark = (i == DEPTH - 1) ? cmd.tail_mark : cell_mark[R];

		bse_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CW         (CW),
			.DEPTH      (DEPTH),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (cell_pos),
			.word       (cell_word),
			.left_data  (cell_data[L]),
			.left_mark  (cell_mark[L]),
			.right_data (cell_data[R]),
			.right_mark (r_mark),
			.data       (cell_data[i]),
			.mark       (cell_mark[i])
		);
	end

endmodule

>>> rtl/bse_cell.sv
// One cell of the list chain: holds one entry word and a delete mark.
// Depends on bse_pkg for the broadcast command type.
module bse_cell import bse_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int CW         = 9,
	parameter int DEPTH      = 256,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [CW-1:0]         pos,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  left_mark,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  right_mark,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  mark
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);
	localparam logic          PARITY = 1'(IDX % 2);
	localparam bit            HAS_R  = (IDX + 1) < DEPTH;
	localparam bit            HAS_L  = IDX > 0;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  mark_q;
	logic                  left_role;
	logic                  right_role;

	// Pairing for the odd-even compaction pass
	assign left_role  = HAS_R && (cmd.phase == PARITY);
	assign right_role = HAS_L && (cmd.phase != PARITY);

	// Update the entry from the broadcast command and the neighbors
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_ROT: begin
				data_q <= right_data;
				mark_q <= right_mark;
			end
			CELL_INS: begin
				if (MY_IDX > pos) begin
					data_q <= left_data;
				end else if (MY_IDX == pos) begin
					data_q <= word;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= pos) begin
					data_q <= right_data;
				end
			end
			CELL_SET: begin
				if (MY_IDX == pos) begin
					data_q <= word;
				end
			end
			CELL_SWAP: begin
				if (left_role && mark_q && !right_mark) begin
					data_q <= right_data;
					mark_q <= 1'b0;
				end else if (right_role && left_mark && !mark_q) begin
					data_q <= left_data;
					mark_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;
	assign mark = mark_q;

endmodule

>>> rtl/bse_ctrl.sv
// Request sequencer: checks requests, drives the cell chain, builds results.
// Depends on bse_pkg for kinds, status codes, states and the cell command.
module bse_ctrl import bse_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int DEPTH      = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [KIND_W-1:0]             kind,
	input  logic [POS_W-1:0]              position,
	input  logic [DATA_WIDTH-1:0]         word,
	input  logic [CAP_W-1:0]              capacity,
	input  logic [DATA_WIDTH-1:0]         head_data,
	output logic                          busy,
	output logic                          done,
	output cell_cmd_t                     cmd,
	output logic [$clog2(DEPTH+1)-1:0]    cell_pos,
	output logic [DATA_WIDTH-1:0]         cell_word,
	output logic [1:0]                    status,
	output logic [INDEX_W-1:0]            result_index,
	output logic [DATA_WIDTH-1:0]         read_value,
	output logic [LEN_W-1:0]              removed_count,
	output logic [LEN_W-1:0]              length
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	state_t                state_q, state_d;
	logic [IW-1:0]         cnt_q;
	logic [KIND_W-1:0]     kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]         count_q;
	logic                  found_q;
	status_t               status_q;
	logic [IW-1:0]         rindex_q;
	logic [DATA_WIDTH-1:0] rvalue_q;
	logic [CW-1:0]         removed_q;

	logic [PW-1:0] pos_x, cnt_x, count_x, usable;
	logic          full, last, in_list, head_hit, head_ge;

	assign pos_x    = PW'(pos_q);
	assign cnt_x    = PW'(cnt_q);
	assign count_x  = PW'(count_q);
	assign usable   = (PW'(capacity) > PW'(DEPTH)) ? PW'(DEPTH) : PW'(capacity);
	assign full     = count_x >= usable;
	assign last     = cnt_q == IW'(DEPTH - 1);
	assign in_list  = cnt_x < count_x;
	assign head_hit = head_data == word_q;
	assign head_ge  = word_q <= head_data;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell command
	always_comb begin
		state_d       = state_q;
		cmd.op        = CELL_HOLD;
		cmd.phase     = cnt_q[0];
		cmd.tail_mark = !in_list || head_hit;
		cell_pos      = CW'(pos_q);
		cell_word     = word_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				case (kind_q)
					KIND_INSERT_AT: begin
						if (!(pos_x > count_x) && !full) begin
							cmd.op = CELL_INS;
						end
					end
					KIND_SORTED: begin
						if (!full) begin
							state_d = S_SCAN;
						end
					end
					KIND_ERASE_AT: begin
						if (pos_x < count_x) begin
							cmd.op = CELL_DEL;
						end
					end
					KIND_SET: begin
						if (pos_x < count_x) begin
							cmd.op = CELL_SET;
						end
					end
					KIND_REMOVE, KIND_GET, KIND_FIND: begin
						state_d = S_SCAN;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				cmd.op = CELL_ROT;
				if (last) begin
					case (kind_q)
						KIND_SORTED: state_d = S_EDIT;
						KIND_REMOVE: state_d = S_SORT;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_EDIT: begin
				cmd.op   = CELL_INS;
				cell_pos = found_q ? CW'(rindex_q) : count_q;
				state_d  = S_DONE;
			end
			S_SORT: begin
				cmd.op = CELL_SWAP;
				if (last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control counters and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
				end
				S_DECIDE: begin
					if (kind_q == KIND_INSERT_AT && !(pos_x > count_x) && !full) begin
						count_q <= count_q + 1'b1;
					end else if (kind_q == KIND_ERASE_AT && pos_x < count_x) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_SCAN: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if ((kind_q == KIND_SORTED && head_ge || kind_q == KIND_FIND && head_hit)
							&& in_list) begin
						found_q <= 1'b1;
					end
				end
				S_EDIT: begin
					count_q <= count_q + 1'b1;
				end
				S_SORT: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) begin
						count_q <= count_q - removed_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request beat and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q    <= kind;
					pos_q     <= position;
					word_q    <= word;
					status_q  <= ST_OK;
					rindex_q  <= '0;
					rvalue_q  <= '0;
					removed_q <= '0;
				end
			end
			S_DECIDE: begin
				case (kind_q)
					KIND_INSERT_AT: begin
						if (pos_x > count_x) begin
							status_q <= ST_BAD_POS;
						end else if (full) begin
							status_q <= ST_FULL;
						end
					end
					KIND_SORTED: begin
						if (full) begin
							status_q <= ST_FULL;
						end
					end
					KIND_ERASE_AT, KIND_GET, KIND_SET: begin
						if (!(pos_x < count_x)) begin
							status_q <= ST_BAD_POS;
						end
					end
					KIND_FIND: begin
						status_q <= ST_NOTFOUND;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (in_list) begin
					if (kind_q == KIND_SORTED && !found_q && head_ge) begin
						rindex_q <= cnt_q;
					end
					if (kind_q == KIND_FIND && !found_q && head_hit) begin
						rindex_q <= cnt_q;
						status_q <= ST_OK;
					end
					if (kind_q == KIND_REMOVE && head_hit) begin
						removed_q <= removed_q + 1'b1;
					end
					if (kind_q == KIND_GET && cnt_x == pos_x) begin
						rvalue_q <= head_data;
					end
				end
			end
			S_EDIT: begin
				if (!found_q) begin
					rindex_q <= IW'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy          = state_q != S_IDLE;
	assign done          = state_q == S_DONE;
	assign status        = status_q;
	assign result_index  = INDEX_W'(rindex_q);
	assign read_value    = rvalue_q;
	assign removed_count = LEN_W'(removed_q);
	assign length        = LEN_W'(count_q);

endmodule

>>> rtl/bse_checker.sv
// Port-level checks for the bounded sequence engine, bound to the top level.
// Depends on bse_pkg for the status codes.
module bse_checker import bse_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [INDEX_W-1:0] result_index,
	input logic [LEN_W-1:0]   removed_count
);

	// An accepted request raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	// A result only follows a request in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	// A result beat lasts one cycle and frees the block
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result beat held or block stayed busy");

	// A failed find reports index zero and removes nothing
	a_notfound_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NOTFOUND) |-> (result_index == '0 && removed_count == '0))
		else $error("not-found result carries index or removed count");

endmodule

bind bounded_sequence_engine bse_checker u_bse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.result_index  (result_index),
	.removed_count (removed_count)
);

>>> sim/tb_bounded_sequence_engine.sv
// Self-checking testbench for bounded_sequence_engine: directed table, then random requests
// across several capacity settings, each result checked against the row's expected outcome or a built-in list model.
// Depends on rtl/bse_pkg.sv and rtl/bounded_sequence_engine.sv.
module tb_bounded_sequence_engine;
	timeunit 1ns;
	timeprecision 1ps;
	import bse_pkg::*;

	localparam int LIST_DEPTH = 256;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(4 * REG_CAPACITY);
	localparam int N_DIR = 22;
	localparam int N_PHASE = 10;
	localparam int PHASE_ITEMS = 180;

	typedef struct {
		logic [1:0]         st;
		logic [INDEX_W-1:0] idx;
		logic [WORD_W-1:0]  rval;
		logic [LEN_W-1:0]   removed;
		logic [LEN_W-1:0]   len;
	} outcome_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] val;
		bit                typed;
		outcome_t          want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_W-1:0] pwdata = '0;
	logic [APB_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [KIND_W-1:0] kind = '0;
	logic [POS_W-1:0] position = '0;
	logic [WORD_W-1:0] item_value = '0;
	logic done;
	logic [1:0] status;
	logic [INDEX_W-1:0] result_index;
	logic [WORD_W-1:0] read_value;
	logic [LEN_W-1:0] removed_count;
	logic [LEN_W-1:0] length;

	// List model state
	logic [WORD_W-1:0] list_mem [LIST_DEPTH];
	int list_len;
	int cap_reg;

	outcome_t pending_results[$];
	int fail_count = 0;
	dir_row_t dir_tab [N_DIR];

	bounded_sequence_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.kind(kind), .position(position), .item_value(item_value),
		.done(done), .status(status), .result_index(result_index),
		.read_value(read_value), .removed_count(removed_count), .length(length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Shift up and place one word
	task automatic place_word(input int at, input logic [WORD_W-1:0] w);
		for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
		list_mem[at] = w;
		list_len++;
	endtask

	// Apply one request to the list model and return its outcome
	task automatic apply_request(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
			input logic [WORD_W-1:0] v, output outcome_t r);
		int usable;
		int i;
		int w;
		bit full;
		usable = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
		full = (list_len >= usable);
		r = '{ST_OK, '0, '0, '0, '0};
		case (k)
			KIND_INSERT_AT: begin
				if (int'(p) > list_len) r.st = ST_BAD_POS;
				else if (full) r.st = ST_FULL;
				else place_word(int'(p), v);
			end
			KIND_SORTED: begin
				if (full) r.st = ST_FULL;
				else begin
					i = 0;
					while (i < list_len && v > list_mem[i]) i++;
					place_word(i, v);
					r.idx = INDEX_W'(i);
				end
			end
			KIND_ERASE_AT: begin
				if (int'(p) >= list_len) r.st = ST_BAD_POS;
				else begin
					for (i = int'(p); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			KIND_REMOVE: begin
				w = 0;
				for (i = 0; i < list_len; i++) begin
					if (list_mem[i] == v) r.removed++;
					else begin
						list_mem[w] = list_mem[i];
						w++;
					end
				end
				list_len = w;
			end
			KIND_GET: begin
				if (int'(p) >= list_len) r.st = ST_BAD_POS;
				else r.rval = list_mem[p];
			end
			KIND_SET: begin
				if (int'(p) >= list_len) r.st = ST_BAD_POS;
				else list_mem[p] = v;
			end
			KIND_FIND: begin
				r.st = ST_NOTFOUND;
				for (i = 0; i < list_len; i++) begin
					if (list_mem[i] == v) begin
						r.st = ST_OK;
						r.idx = INDEX_W'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		r.len = LEN_W'(list_len);
	endtask

	// Issue one request beat after a random gap; queue its outcome on acceptance
	task automatic send_request(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
			input logic [WORD_W-1:0] v, input bit typed, input outcome_t want);
		int gap;
		outcome_t r;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		position <= p;
		item_value <= v;
		do @(posedge clk); while (busy);
		apply_request(k, p, v, r);
		pending_results.push_back(typed ? want : r);
	endtask

	// Write the capacity register and read it back
	task automatic set_capacity(input int c);
		logic [APB_W-1:0] got;
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_CAPACITY; pwdata <= APB_W'(c);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		cap_reg = c & 'h1FF;
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0; penable <= 1'b0;
		if (got[CAP_W-1:0] != CAP_W'(cap_reg)) begin
			$error("capacity readback: expected %0d, actual %0d", cap_reg, got[CAP_W-1:0]);
			fail_count++;
		end
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return WORD_W'($urandom_range(0, 5));
		if (r == 7) return '1;
		return $urandom;
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return KIND_INSERT_AT;
		if (r < 45) return KIND_SORTED;
		if (r < 55) return KIND_ERASE_AT;
		if (r < 60) return KIND_REMOVE;
		if (r < 72) return KIND_GET;
		if (r < 84) return KIND_SET;
		if (r < 97) return KIND_FIND;
		return KIND_UNUSED;
	endfunction

	// Compare each result beat with the oldest outcome
	always @(posedge clk) begin
		outcome_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no request waiting");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					fail_count++;
				end
				if (result_index !== e.idx) begin
					$error("result_index: expected %0d, actual %0d", e.idx, result_index);
					fail_count++;
				end
				if (read_value !== e.rval) begin
					$error("read_value: expected %h, actual %h", e.rval, read_value);
					fail_count++;
				end
				if (removed_count !== e.removed) begin
					$error("removed_count: expected %0d, actual %0d", e.removed, removed_count);
					fail_count++;
				end
				if (length !== e.len) begin
					$error("length: expected %0d, actual %0d", e.len, length);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int caps [N_PHASE];
		int wait_cycles;
		logic [POS_W-1:0] p;
		outcome_t none;
		none = '{ST_OK, '0, '0, '0, '0};
		for (int i = 0; i < LIST_DEPTH; i++) list_mem[i] = '0;
		list_len = 0;
		cap_reg = 256;

		// Directed rows: empty-list rejects, extremes, then each operation
		dir_tab = '{
			'{KIND_GET,       9'd0,   32'h0,        1, '{ST_BAD_POS,  8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_ERASE_AT,  9'd0,   32'h0,        1, '{ST_BAD_POS,  8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_FIND,      9'd0,   32'h0,        1, '{ST_NOTFOUND, 8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_INSERT_AT, 9'd1,   32'h7,        1, '{ST_BAD_POS,  8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_SET,       9'd0,   32'h7,        1, '{ST_BAD_POS,  8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_REMOVE,    9'd0,   32'h5,        1, '{ST_OK,       8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_UNUSED,    9'd511, 32'hFFFFFFFF, 1, '{ST_OK,       8'd0, 32'h0, 9'd0, 9'd0}},
			'{KIND_INSERT_AT, 9'd0,   32'hFFFFFFFF, 1, '{ST_OK,       8'd0, 32'h0, 9'd0, 9'd1}},
			'{KIND_SORTED,    9'd0,   32'h0,        1, '{ST_OK,       8'd0, 32'h0, 9'd0, 9'd2}},
			'{KIND_SORTED,    9'd0,   32'h80000000, 0, none},
			'{KIND_INSERT_AT, 9'd3,   32'h5,        0, none},
			'{KIND_INSERT_AT, 9'd511, 32'h5,        1, '{ST_BAD_POS,  8'd0, 32'h0, 9'd0, 9'd4}},
			'{KIND_GET,       9'd0,   32'h0,        1, '{ST_OK,       8'd0, 32'h0, 9'd0, 9'd4}},
			'{KIND_GET,       9'd3,   32'h0,        0, none},
			'{KIND_SET,       9'd1,   32'h12345678, 0, none},
			'{KIND_FIND,      9'd0,   32'hFFFFFFFF, 0, none},
			'{KIND_SORTED,    9'd0,   32'h5,        0, none},
			'{KIND_REMOVE,    9'd0,   32'h5,        0, none},
			'{KIND_ERASE_AT,  9'd0,   32'h0,        0, none},
			'{KIND_ERASE_AT,  9'd256, 32'h0,        0, none},
			'{KIND_GET,       9'd511, 32'h0,        0, none},
			'{KIND_UNUSED,    9'd0,   32'h0,        0, none}
		};
		caps = '{1, 2, 0, 256, 5, 300, 511, 16, 0, 256};
		caps[8] = $urandom_range(1, 256);

		// Hold reset, then release
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_request(dir_tab[i].kind, dir_tab[i].pos, dir_tab[i].val,
				dir_tab[i].typed, dir_tab[i].want);

		// Random phases, one capacity setting each
		for (int ph = 0; ph < N_PHASE; ph++) begin
			set_capacity(caps[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 9) == 0) p = POS_W'($urandom_range(0, 511));
				else p = POS_W'($urandom_range(0, list_len + 1));
				send_request(pick_kind(), p, pick_word(), 0, none);
			end
		end
		start <= 1'b0;

		// Drain, then allow the longest request time for stray beats
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (600) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

>>> filelist.f
rtl/bse_pkg.sv
rtl/bse_cell.sv
rtl/bse_ctrl.sv
rtl/bounded_sequence_engine.sv
rtl/bse_checker.sv
sim/tb_bounded_sequence_engine.sv
